### src/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and the arctangent table for the Euler to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_W      = 16;
	localparam int QUAT_W       = 16;
	localparam int SINCOS_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int CW           = 34;   // CORDIC datapath width, Q.30 plus headroom
	localparam int TW           = 17;   // sine/cosine width, Q.15 up to +/-1.0
	localparam int PW           = 34;   // product of two Q.15 values
	localparam int SW           = 52;   // sum of two triple products, Q.45

	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
	localparam logic signed [CW-1:0]      CORDIC_X0   = 34'sd652032874;
	localparam logic signed [TW-1:0]      TRIG_ONE    = 17'sd32768;
	localparam logic signed [QUAT_W-1:0]  QUAT_ONE    = 16'sd16384;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [TW-1:0] trig_t;

	typedef struct packed {
		trig_t s;
		trig_t c;
	} sc_t;

	function automatic cval_t atan_q30(input int i);
		cval_t r;
		r = '0;
		unique case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/euler_to_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Euler angles (Q3.13 radians) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per beat: angle_x, angle_y, angle_z packed
//   in tdata from bit 0 up. m_axis returns quat_w, quat_x, quat_y, quat_z.
//   Angles beyond +/-pi are saturated; outputs are saturated to +/-1.0.
//   Throughput: one request per cycle while m_axis is not stalled. Stages:
//   one clamp stage, one stage per CORDIC step, one rounding stage, four
//   combine stages (pair products, triple products, sums, rounding).
//   The whole pipeline advances only when its last stage is empty or taken,
//   so a stall on m_axis freezes every stage; s_axis_tready follows.
//   Reset clears all valid bits; no request is in flight after it.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
	parameter int SINCOS_STEPS = e2q_pkg::SINCOS_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // angle_x, angle_y, angle_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);
	import e2q_pkg::*;

	localparam int NS = (SINCOS_STEPS < TABLE_LEN) ? SINCOS_STEPS : TABLE_LEN;
	localparam int LAT = NS + 6;

	logic [LAT-1:0] vld_q;
	logic en;
	sc_t sc1, sc2, sc3;
	logic signed [QUAT_W-1:0] qw, qx, qy, qz;

	assign en = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	e2q_cordic #(.STEPS(SINCOS_STEPS)) u_cx (
		.clk(clk), .en(en),
		.angle(s_axis_tdata[15:0]), .sc(sc1));
	e2q_cordic #(.STEPS(SINCOS_STEPS)) u_cy (
		.clk(clk), .en(en),
		.angle(s_axis_tdata[31:16]), .sc(sc2));
	e2q_cordic #(.STEPS(SINCOS_STEPS)) u_cz (
		.clk(clk), .en(en),
		.angle(s_axis_tdata[47:32]), .sc(sc3));

	e2q_combine u_comb (
		.clk(clk), .en(en),
		.a1(sc1), .a2(sc2), .a3(sc3),
		.qw(qw), .qx(qx), .qy(qy), .qz(qz));

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata  = {qz, qy, qx, qw};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(qw) <= QUAT_ONE && $signed(qw) >= -QUAT_ONE)
		else $error("quat_w out of range");

endmodule

### src/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: clamped Q3.13 angle in, sine and cosine
// of the half angle out as Q.15, one CORDIC step per stage.
// ----------------------------------------------------------------------------
module e2q_cordic #(
	parameter int STEPS = e2q_pkg::SINCOS_STEPS
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [e2q_pkg::ANGLE_W-1:0]      angle,
	output e2q_pkg::sc_t                            sc
);
	import e2q_pkg::*;

	localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

	cval_t x_s [N+1];
	cval_t y_s [N+1];
	cval_t z_s [N+1];
	logic signed [ANGLE_W-1:0] ang_c;
	cval_t xr, yr;
	logic signed [CW-16:0] xs, ys;
	sc_t sc_q;

	always_comb begin
		if (angle > ANGLE_LIMIT) begin
			ang_c = ANGLE_LIMIT;
		end else if (angle < -ANGLE_LIMIT) begin
			ang_c = -ANGLE_LIMIT;
		end else begin
			ang_c = angle;
		end
	end

	// clamped raw value read as Q.14 half angle, moved to Q.30
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_X0;
			y_s[0] <= '0;
			z_s[0] <= {{(CW-ANGLE_W-16){ang_c[ANGLE_W-1]}}, ang_c, 16'd0};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	assign xr = x_s[N] + cval_t'(16384);
	assign yr = y_s[N] + cval_t'(16384);
	assign xs = xr[CW-1:15];
	assign ys = yr[CW-1:15];

	function automatic trig_t sat(input logic signed [CW-16:0] v);
		if (v > TRIG_ONE) return TRIG_ONE;
		if (v < -TRIG_ONE) return -TRIG_ONE;
		return trig_t'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sc_q.c <= sat(xs);
			sc_q.s <= sat(ys);
		end
	end

	assign sc = sc_q;

endmodule

### src/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the four quaternion components from three sine/cosine pairs:
// pair products, triple products, sums, then rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_combine (
	input  logic                                clk,
	input  logic                                en,
	input  e2q_pkg::sc_t                        a1,
	input  e2q_pkg::sc_t                        a2,
	input  e2q_pkg::sc_t                        a3,
	output logic signed [e2q_pkg::QUAT_W-1:0]   qw,
	output logic signed [e2q_pkg::QUAT_W-1:0]   qx,
	output logic signed [e2q_pkg::QUAT_W-1:0]   qy,
	output logic signed [e2q_pkg::QUAT_W-1:0]   qz
);
	import e2q_pkg::*;

	localparam int TP = PW + TW;   // triple product width

	logic signed [PW-1:0] c2c1_s1, s2s1_s1, c2s1_s1, s2c1_s1;
	trig_t s3_s1, c3_s1;
	logic signed [TP-1:0] t0_s2, t1_s2, t2_s2, t3_s2, t4_s2, t5_s2, t6_s2, t7_s2;
	logic signed [SW-1:0] w_s3, x_s3, y_s3, z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			c2c1_s1 <= PW'(a2.c * a1.c);
			s2s1_s1 <= PW'(a2.s * a1.s);
			c2s1_s1 <= PW'(a2.c * a1.s);
			s2c1_s1 <= PW'(a2.s * a1.c);
			s3_s1   <= a3.s;
			c3_s1   <= a3.c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s2 <= TP'(c2c1_s1 * c3_s1);
			t1_s2 <= TP'(s2s1_s1 * s3_s1);
			t2_s2 <= TP'(c2s1_s1 * c3_s1);
			t3_s2 <= TP'(s2c1_s1 * s3_s1);
			t4_s2 <= TP'(s2c1_s1 * c3_s1);
			t5_s2 <= TP'(c2s1_s1 * s3_s1);
			t6_s2 <= TP'(s2s1_s1 * c3_s1);
			t7_s2 <= TP'(c2c1_s1 * s3_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= SW'(t0_s2) - SW'(t1_s2) + (SW'(1) <<< 30);
			x_s3 <= SW'(t2_s2) - SW'(t3_s2) + (SW'(1) <<< 30);
			y_s3 <= SW'(t4_s2) + SW'(t5_s2) + (SW'(1) <<< 30);
			z_s3 <= SW'(t6_s2) + SW'(t7_s2) + (SW'(1) <<< 30);
		end
	end

	function automatic logic signed [QUAT_W-1:0] outq(input logic signed [SW-1:0] v);
		logic signed [SW-32:0] r;
		r = v[SW-1:31];
		if (r > QUAT_ONE) return QUAT_ONE;
		if (r < -QUAT_ONE) return -QUAT_ONE;
		return QUAT_W'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			qw <= outq(w_s3);
			qx <= outq(x_s3);
			qy <= outq(y_s3);
			qz <= outq(z_s3);
		end
	end

endmodule
